>>> sv/mtfc_pkg.sv
// ----------------------------------------------------------------------------
// mtfc_pkg
// Types and constants shared by the move-to-front codec modules.
// ----------------------------------------------------------------------------
package mtfc_pkg;

  localparam int SYM_W     = 8;
  localparam int POS_W     = 8;
  localparam int LEN_W     = 9;
  localparam int GRP_SIZE  = 16;
  localparam int GRP_BITS  = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  localparam logic REG_LIST_SIZE = 1'b0;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SYM_W-1:0] symbol_in;
    logic [POS_W-1:0] position_in;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position_out;
    logic [SYM_W-1:0] symbol_out;
    logic             miss;
  } out_item_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [1:0]       op;
    logic [SYM_W-1:0] key;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] act_len;
    logic             hit_en;
    logic             move_en;
    logic             load_en;
    logic [POS_W-1:0] front_pos;
  } cell_ctl_t;

  typedef struct packed {
    logic                any;
    logic [GRP_BITS-1:0] off;
    logic [SYM_W-1:0]    sym;
  } grp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_SELECT,
    S_MOVE
  } state_t;

endpackage

>>> sv/mtfc_cell.sv
// ----------------------------------------------------------------------------
// mtfc_cell
// One list slot: holds a symbol, flags a hit, takes its neighbor's symbol on
// a move-to-front shift.
// ----------------------------------------------------------------------------
module mtfc_cell #(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mtfc_pkg::cell_ctl_t      ctl,
  input  logic [mtfc_pkg::SYM_W-1:0] prev_sym,
  output logic [mtfc_pkg::SYM_W-1:0] sym,
  output logic                     hit
);
  import mtfc_pkg::*;

  localparam logic [LEN_W-1:0] IDX = LEN_W'(INDEX);

  logic hit_next;
  logic active;

  assign active = IDX < ctl.act_len;

  always_comb begin
    unique case (ctl.op)
      OP_ENCODE: hit_next = active && (sym == ctl.key);
      OP_DECODE: hit_next = active && (IDX == {1'b0, ctl.pos});
      default:   hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.hit_en) begin
      hit <= hit_next;
    end
  end

  // cell 0 sees the front symbol as its neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      sym <= SYM_W'(INDEX);
    end else if (ctl.load_en && (IDX == {1'b0, ctl.pos})) begin
      sym <= ctl.key;
    end else if (ctl.move_en && (IDX <= {1'b0, ctl.front_pos})) begin
      sym <= prev_sym;
    end
  end

endmodule

>>> sv/mtfc_group.sv
// ----------------------------------------------------------------------------
// mtfc_group
// Registered first-hit encoder over one group of cells: offset of the lowest
// hit and the symbol held there.
// ----------------------------------------------------------------------------
module mtfc_group (
  input  logic                                       clk,
  input  logic [mtfc_pkg::GRP_SIZE-1:0]              hit,
  input  logic [mtfc_pkg::GRP_SIZE-1:0][mtfc_pkg::SYM_W-1:0] sym,
  output mtfc_pkg::grp_res_t                         res
);
  import mtfc_pkg::*;

  grp_res_t res_next;

  always_comb begin
    res_next = '0;
    for (int k = GRP_SIZE - 1; k >= 0; k--) begin
      if (hit[k]) begin
        res_next.any = 1'b1;
        res_next.off = GRP_BITS'(k);
        res_next.sym = sym[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

>>> sv/move_to_front_codec_unit.sv
// ----------------------------------------------------------------------------
// move_to_front_codec_unit
// Move-to-front list of symbols held in a chain of cells; load, encode and
// decode beats with an APB register for the active list size.
// ----------------------------------------------------------------------------
// The list lives in LIST_DEPTH cells, one symbol each, reset to identity
// order. Every beat runs from acceptance to its registered result through
// compare in all cells, first-hit encode per group of 16 cells, group
// select, then a shift in which each cell up to the hit takes its
// neighbor's symbol; a new beat is accepted on the cycle after the shift,
// even if the previous result is still held on the output, and not before,
// so only one beat is in flight. A stalled output holds the shift until it frees.
// list_size is at byte address 0; its effective value is clamped to LIST_DEPTH.
module move_to_front_codec_unit #(
  parameter int LIST_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mtfc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mtfc_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mtfc_pkg::*;

  localparam int NUM_GRP = (LIST_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NUM_PAD = NUM_GRP * GRP_SIZE;

  state_t state, state_next;

  logic [LEN_W-1:0] list_size;
  logic [LEN_W-1:0] act_len;

  in_item_t  item;
  out_item_t res_next;

  logic             found;
  logic [POS_W-1:0] front_pos;
  logic [SYM_W-1:0] front_sym;

  logic             found_next;
  logic [POS_W-1:0] front_pos_next;
  logic [SYM_W-1:0] front_sym_next;

  logic accept, out_free, hit_en, out_load, load_oob;

  cell_ctl_t ctl;

  logic [NUM_GRP-1:0][GRP_SIZE-1:0]            hit_grp;
  logic [NUM_GRP-1:0][GRP_SIZE-1:0][SYM_W-1:0] sym_grp;
  grp_res_t                                    grp_res [NUM_GRP];

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = 32'(list_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      list_size <= LEN_W'(256);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIST_SIZE)) begin
      list_size <= pwdata[LEN_W-1:0];
    end
  end

  assign act_len = (list_size > LEN_W'(LIST_DEPTH)) ? LEN_W'(LIST_DEPTH) : list_size;

  // ---------------- sequencer ----------------
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_oob = {1'b0, item.position_in} >= LEN_W'(LIST_DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_MATCH;
      S_MATCH:  state_next = S_GROUP;
      S_GROUP:  state_next = S_SELECT;
      S_SELECT: state_next = S_MOVE;
      S_MOVE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    hit_en   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE:   in_stall = 1'b0;
      S_MATCH:  hit_en   = 1'b1;
      S_MOVE:   out_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  // ---------------- cell chain ----------------
  always_comb begin
    ctl           = '0;
    ctl.op        = item.opcode;
    ctl.key       = item.symbol_in;
    ctl.pos       = item.position_in;
    ctl.act_len   = act_len;
    ctl.hit_en    = hit_en;
    ctl.move_en   = out_load && found &&
                    ((item.opcode == OP_ENCODE) || (item.opcode == OP_DECODE));
    ctl.load_en   = out_load && (item.opcode == OP_LOAD) && !load_oob;
    ctl.front_pos = front_pos;
  end

  for (genvar j = 0; j < NUM_PAD; j++) begin : g_cell
    if (j < LIST_DEPTH) begin : g_real
      logic [SYM_W-1:0] prev;
      if (j == 0) begin : g_head
        assign prev = front_sym;
      end else begin : g_link
        assign prev = sym_grp[(j-1)/GRP_SIZE][(j-1)%GRP_SIZE];
      end
      mtfc_cell #(.INDEX(j)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .prev_sym (prev),
        .sym      (sym_grp[j/GRP_SIZE][j%GRP_SIZE]),
        .hit      (hit_grp[j/GRP_SIZE][j%GRP_SIZE])
      );
    end else begin : g_pad
      assign sym_grp[j/GRP_SIZE][j%GRP_SIZE] = '0;
      assign hit_grp[j/GRP_SIZE][j%GRP_SIZE] = 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    mtfc_group u_group (
      .clk (clk),
      .hit (hit_grp[g]),
      .sym (sym_grp[g]),
      .res (grp_res[g])
    );
  end

  // lowest group with a hit wins
  always_comb begin
    found_next     = 1'b0;
    front_pos_next = '0;
    front_sym_next = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_res[g].any) begin
        found_next     = 1'b1;
        front_pos_next = {GRP_BITS'(g), grp_res[g].off};
        front_sym_next = grp_res[g].sym;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SELECT) begin
      found     <= found_next;
      front_pos <= front_pos_next;
      front_sym <= front_sym_next;
    end
  end

  // ---------------- result ----------------
  always_comb begin
    res_next = '0;
    unique case (item.opcode)
      OP_LOAD:   res_next.miss = load_oob;
      OP_ENCODE: begin
        res_next.miss = !found;
        if (found) res_next.position_out = front_pos;
      end
      OP_DECODE: begin
        res_next.miss = !found;
        if (found) res_next.symbol_out = front_sym;
      end
      default:   res_next.miss = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res_next;
    end
  end

  // ---------------- assertions ----------------
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("beat accepted while another is in flight");

  a_result_from_move: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_MOVE))
    else $error("result raised outside the move cycle");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE && found) |-> ({1'b0, front_pos} < act_len))
    else $error("selected position beyond active list");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for move_to_front_codec_unit. A local copy of the
// symbol list predicts every result beat, which is checked field by field.
// Directed beats come first, then random load/encode/decode beats under
// several list sizes and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import mtfc_pkg::*;

  localparam int         LIST_DEPTH     = 256;
  localparam logic [2:0] LIST_SIZE_ADDR = {REG_LIST_SIZE, 2'b00};
  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         PHASE_BEATS    = 312;

  logic      clk      = 1'b0;
  logic      rst      = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [SYM_W-1:0] mtf_list [LIST_DEPTH];
  logic [LEN_W-1:0] list_size_cfg;
  out_item_t        pending_results [$];

  int mismatches    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  move_to_front_codec_unit #(.LIST_DEPTH(LIST_DEPTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int active_len();
    return (list_size_cfg > LIST_DEPTH) ? LIST_DEPTH : int'(list_size_cfg);
  endfunction

  function automatic void promote_entry(int p);
    logic [SYM_W-1:0] s;
    s = mtf_list[p];
    for (int i = p; i > 0; i--) mtf_list[i] = mtf_list[i-1];
    mtf_list[0] = s;
  endfunction

  function automatic out_item_t mtf_predict(in_item_t beat);
    out_item_t res;
    int        n;
    int        hit;
    res = '0;
    n   = active_len();
    hit = -1;
    case (beat.opcode)
      OP_LOAD: begin
        // position_in is 8 bits, so every load lands inside the list
        mtf_list[beat.position_in] = beat.symbol_in;
      end
      OP_ENCODE: begin
        for (int i = 0; i < n; i++)
          if (hit < 0 && mtf_list[i] == beat.symbol_in) hit = i;
        if (hit < 0) begin
          res.miss = 1'b1;
        end else begin
          res.position_out = POS_W'(hit);
          promote_entry(hit);
        end
      end
      OP_DECODE: begin
        if (int'(beat.position_in) < n) begin
          res.symbol_out = mtf_list[beat.position_in];
          promote_entry(int'(beat.position_in));
        end else begin
          res.miss = 1'b1;
        end
      end
      default: res.miss = 1'b1;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic in_item_t mk_beat(logic [1:0] op, logic [SYM_W-1:0] sym,
                                       logic [POS_W-1:0] pos);
    in_item_t b;
    b.opcode      = op;
    b.symbol_in   = sym;
    b.position_in = pos;
    return b;
  endfunction

  task automatic send_beat(in_item_t beat);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(mtf_predict(beat));
  endtask

  task automatic sender_rest();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // only written with the block idle; pending results drain, then spare cycles cover the pipeline
  task automatic set_list_size(int value);
    sender_rest();
    wait_drain();
    repeat (8) @(posedge clk);
    apb_write(LIST_SIZE_ADDR, 32'(value));
    list_size_cfg = LEN_W'(value);
  endtask

  function automatic in_item_t rand_beat();
    int r;
    int n;
    r = $urandom_range(99);
    n = active_len();
    if (r < 12)
      return mk_beat(OP_LOAD, SYM_W'($urandom), POS_W'($urandom));
    if (r < 55) begin
      if (n > 0 && $urandom_range(99) < 80)
        return mk_beat(OP_ENCODE, mtf_list[$urandom_range(n-1, 0)], POS_W'($urandom));
      return mk_beat(OP_ENCODE, SYM_W'($urandom), POS_W'($urandom));
    end
    if (r < 95) begin
      if (n > 0 && $urandom_range(99) < 85)
        return mk_beat(OP_DECODE, SYM_W'($urandom), POS_W'($urandom_range(n-1, 0)));
      return mk_beat(OP_DECODE, SYM_W'($urandom), POS_W'($urandom));
    end
    return mk_beat(OP_UNUSED, SYM_W'($urandom), POS_W'($urandom));
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(negedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.position_out !== want.position_out) begin
          $display("%0t position_out: expected %0d, got %0d",
                   $time, want.position_out, out_data.position_out);
          mismatches++;
        end
        if (out_data.symbol_out !== want.symbol_out) begin
          $display("%0t symbol_out: expected %0d, got %0d",
                   $time, want.symbol_out, out_data.symbol_out);
          mismatches++;
        end
        if (out_data.miss !== want.miss) begin
          $display("%0t miss: expected %0b, got %0b", $time, want.miss, out_data.miss);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_identity_after_reset();
    send_beat(mk_beat(OP_ENCODE, 8'd0, 8'd0));
    send_beat(mk_beat(OP_ENCODE, 8'd255, 8'd255));   // last entry jumps to front
    send_beat(mk_beat(OP_DECODE, 8'd0, 8'd0));
    send_beat(mk_beat(OP_DECODE, 8'hFF, 8'd255));
    send_beat(mk_beat(OP_ENCODE, 8'd128, 8'h00));
  endtask

  task automatic test_duplicates_and_unknown();
    send_beat(mk_beat(OP_LOAD, 8'hAA, 8'd0));
    send_beat(mk_beat(OP_LOAD, 8'h55, 8'd255));
    send_beat(mk_beat(OP_LOAD, 8'd7, 8'd3));        // duplicate of 7 ahead of the old one
    send_beat(mk_beat(OP_ENCODE, 8'd7, 8'd0));
    send_beat(mk_beat(OP_ENCODE, 8'd7, 8'd0));
    send_beat(mk_beat(OP_DECODE, 8'd0, 8'd200));
    send_beat(mk_beat(OP_UNUSED, 8'hFF, 8'hFF));
    send_beat(mk_beat(OP_UNUSED, 8'h00, 8'h00));
  endtask

  task automatic test_empty_list();
    set_list_size(0);
    send_beat(mk_beat(OP_ENCODE, mtf_list[0], 8'd0));
    send_beat(mk_beat(OP_DECODE, 8'd0, 8'd0));
    send_beat(mk_beat(OP_LOAD, 8'h3C, 8'd1));        // loads still write
  endtask

  task automatic test_single_entry_and_clamp();
    set_list_size(1);
    send_beat(mk_beat(OP_DECODE, 8'd0, 8'd0));
    send_beat(mk_beat(OP_DECODE, 8'd0, 8'd1));
    send_beat(mk_beat(OP_ENCODE, mtf_list[0], 8'd0));
    send_beat(mk_beat(OP_ENCODE, mtf_list[1], 8'd0)); // beyond the active length
    // sizes above the depth act as the full list
    set_list_size(511);
    send_beat(mk_beat(OP_DECODE, 8'd0, 8'd255));
    send_beat(mk_beat(OP_ENCODE, mtf_list[255], 8'd0));
  endtask

  task automatic test_random_phase(int idle_pct, int stall_p, int size_a, int size_b);
    sender_rest();
    wait_drain();
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    set_list_size(size_a);
    repeat (PHASE_BEATS / 2) send_beat(rand_beat());
    set_list_size(size_b);
    repeat (PHASE_BEATS / 2) send_beat(rand_beat());
  endtask

  initial begin
    for (int i = 0; i < LIST_DEPTH; i++) mtf_list[i] = SYM_W'(i);
    list_size_cfg = LEN_W'(256);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_identity_after_reset();
    test_duplicates_and_unknown();
    test_empty_list();
    test_single_entry_and_clamp();

    test_random_phase(0, 0, 256, 17);
    test_random_phase(88, 0, 2, 256);
    test_random_phase(0, 88, $urandom_range(256, 1), 1);
    test_random_phase(22, 22, 256, $urandom_range(255, 3));

    sender_rest();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

>>> sim.f
sv/mtfc_pkg.sv
sv/mtfc_cell.sv
sv/mtfc_group.sv
sv/move_to_front_codec_unit.sv
tb/sv/tb.sv
